/* src/sorted_unique_set_unit_macros.svh */
// ----------------------------------------------------------------------------
// sorted_unique_set_unit_macros
// Assertion macros used by the set unit port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_SET_UNIT_MACROS_SVH
`define SORTED_UNIQUE_SET_UNIT_MACROS_SVH

// same-cycle implication
`define SUS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SUS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sus_pkg.sv */
// ----------------------------------------------------------------------------
// sus_pkg
// Types and constants of the sorted unique set unit.
// ----------------------------------------------------------------------------
package sus_pkg;

	localparam int KEY_W = 32;
	localparam int OCC_W = 7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic cmp_en;
		logic ins_en;
		logic del_en;
	} cell_ctl_t;

endpackage

/* src/sus_cell.sv */
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted chain: compares the broadcast key, then keeps its
// value, takes the key, or shifts in a neighbor's value.
// ----------------------------------------------------------------------------
module sus_cell
	import sus_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] key,
	input  logic             occ,
	input  logic             left_lt,
	input  logic [KEY_W-1:0] left_val,
	input  logic [KEY_W-1:0] right_val,
	output logic [KEY_W-1:0] val,
	output logic             lt,
	output logic             eq
);

	logic [KEY_W-1:0] val_q;
	logic             lt_q;
	logic             eq_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_q <= occ & (val_q < key);
			eq_q <= occ & (val_q == key);
		end
		if (ctl.ins_en && !lt_q) begin
			val_q <= left_lt ? key : left_val;
		end else if (ctl.del_en && !lt_q) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

/* src/sorted_unique_set_unit.sv */
// ----------------------------------------------------------------------------
// sorted_unique_set_unit
// Ascending set of distinct signed 32-bit values held in a chain of cells.
// The done strobe is registered from the update state.
// Each op takes a compare state, then an update state, which can accept the next op.
// The result registers free the receiver path; the receiver cannot stall.
// Reset: arst_n clears the count and control; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_unique_set_unit
	import sus_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    opcode,
	input  logic signed [KEY_W-1:0] value,
	output logic                    done,
	output logic                    changed,
	output logic                    full_reject,
	output logic [OCC_W-1:0]        occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic             op_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             done_q;
	logic             changed_q;
	logic             reject_q;
	logic [OCC_W-1:0] occ_q;

	logic [CAPACITY-1:0] occ_v;
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] eq_v;
	logic [KEY_W-1:0]    val_v [CAPACITY];

	logic      accept;
	logic      upd;
	logic      present;
	logic      full;
	logic      ins_go;
	logic      del_go;
	logic      reject;
	cell_ctl_t ctl;

	assign accept  = start && !busy;
	assign upd     = (state_q == ST_UPD);
	assign present = |eq_v;
	assign full    = (count_q == CW'(CAPACITY));
	assign ins_go  = upd && (op_q == OP_INSERT) && !present && !full;
	assign del_go  = upd && (op_q == OP_DELETE) && present;
	assign reject  = (op_q == OP_INSERT) && !present && full;

	assign ctl.cmp_en = (state_q == ST_CMP);
	assign ctl.ins_en = ins_go;
	assign ctl.del_en = del_go;

	always_comb begin
		count_next = count_q;
		if (ins_go) begin
			count_next = count_q + CW'(1);
		end else if (del_go) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= accept ? ST_CMP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			count_q <= count_next;
			done_q  <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {~value[KEY_W-1], value[KEY_W-2:0]};
			op_q  <= opcode;
		end
		if (upd) begin
			changed_q <= ins_go || del_go;
			reject_q  <= reject;
			occ_q     <= OCC_W'(count_next);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic             left_lt;
		logic [KEY_W-1:0] left_val;
		logic [KEY_W-1:0] right_val;

		assign occ_v[i] = (IDX < count_q);

		if (i == 0) begin : g_first
			assign left_lt  = 1'b1;
			assign left_val = key_q;
		end else begin : g_mid
			assign left_lt  = lt_v[i-1];
			assign left_val = val_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = val_v[i];
		end else begin : g_body
			assign right_val = val_v[i+1];
		end

		sus_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key_q),
			.occ       (occ_v[i]),
			.left_lt   (left_lt),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (val_v[i]),
			.lt        (lt_v[i]),
			.eq        (eq_v[i])
		);
	end

	assign busy        = (state_q == ST_CMP);
	assign done        = done_q;
	assign changed     = changed_q;
	assign full_reject = reject_q;
	assign occupancy   = occ_q;

endmodule

/* src/sus_checker.sv */
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks of the sorted unique set unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_unique_set_unit_macros.svh"

module sus_checker
	import sus_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    changed,
	input logic                    full_reject,
	input logic [OCC_W-1:0]        occupancy
);

	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

	`SUS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept without busy")
	`SUS_ASSERT_NEXT(a_busy_single, clk, arst_n, busy, !busy, "busy longer than one cycle")
	`SUS_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##3 done, "result not on time")
	`SUS_ASSERT_IMPL(a_excl, clk, arst_n, done, !(changed && full_reject), "changed and reject")
	`SUS_ASSERT_IMPL(a_reject_full, clk, arst_n, done && full_reject, occupancy == CAP_OCC,
		"reject while not full")

endmodule

bind sorted_unique_set_unit sus_checker #(.CAPACITY(CAPACITY)) u_sus_checker (.*);

/* dv/sorted_unique_set_unit_checker.sv */
// ----------------------------------------------------------------------------
// sorted_unique_set_unit_checker
// Watches the command and result channels of the set unit. Every accepted
// transaction is applied to a local ascending list of held values to predict
// its result; each done strobe is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_unique_set_unit_checker
	import sus_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    opcode,
	input  logic signed [KEY_W-1:0] value,
	input  logic                    done,
	input  logic                    changed,
	input  logic                    full_reject,
	input  logic [OCC_W-1:0]        occupancy,
	input  logic                    run_done,
	output int                      fail_count,
	output int                      pending,
	output int                      results_seen,
	output int                      rejects_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             changed;
		logic             full_reject;
		logic [OCC_W-1:0] occupancy;
	} set_result_t;

	typedef struct {
		logic        op;
		int          key;
		set_result_t res;
	} set_op_rec_t;

	set_op_rec_t result_q[$];
	int          held_values[$];
	int          mismatches = 0;

	initial begin
		pending      = 0;
		results_seen = 0;
		rejects_seen = 0;
	end

	assign fail_count = mismatches + (run_done ? pending : 0);

	// applies one insert/delete to the held list, returns the expected result
	function automatic set_result_t apply_set_op(input logic op, input int key);
		int          slot;
		bit          present;
		set_result_t r;
		slot = 0;
		while (slot < held_values.size() && held_values[slot] < key)
			slot++;
		present = (slot < held_values.size()) && (held_values[slot] == key);
		r = '0;
		if (op == OP_INSERT) begin
			if (!present) begin
				if (held_values.size() >= CAPACITY) begin
					r.full_reject = 1'b1;
				end else begin
					held_values.insert(slot, key);
					r.changed = 1'b1;
				end
			end
		end else if (present) begin
			held_values.delete(slot);
			r.changed = 1'b1;
		end
		r.occupancy = OCC_W'(held_values.size());
		return r;
	endfunction

	always @(posedge clk) begin : monitor
		set_result_t got;
		set_op_rec_t rec;
		if (arst_n) begin
			if (done) begin
				got = {changed, full_reject, occupancy};
				results_seen++;
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result: changed=%0b full_reject=%0b occupancy=%0d",
							$realtime, got.changed, got.full_reject, got.occupancy);
				end else begin
					rec = result_q.pop_front();
					if (got !== rec.res) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("[%0t] %s %0d: expected changed=%0b full_reject=%0b ",
								$realtime, (rec.op == OP_INSERT) ? "insert" : "delete", rec.key,
								rec.res.changed, rec.res.full_reject);
							$display("occupancy=%0d, got changed=%0b full_reject=%0b occupancy=%0d",
								rec.res.occupancy, got.changed, got.full_reject, got.occupancy);
						end
					end
				end
			end
			if (start && !busy) begin
				rec.op  = opcode;
				rec.key = value;
				rec.res = apply_set_op(opcode, value);
				if (rec.res.full_reject)
					rejects_seen++;
				result_q.push_back(rec);
			end
			pending <= result_q.size();
		end
	end

endmodule

/* dv/sorted_unique_set_unit_tb.sv */
// ----------------------------------------------------------------------------
// sorted_unique_set_unit_tb
// Drives insert/delete transactions into the set unit: a directed pass over
// the value extremes and corner cases, then rounds that fill the store past
// capacity, mix inserts and deletes on a full store and drain it again, each
// round at one of three sender idle rates. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module sorted_unique_set_unit_tb
	import sus_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY       = 64;
	localparam int POOL_SIZE      = CAPACITY + 8;
	localparam int ROUNDS         = 4;
	localparam int MIX_ITEMS      = 60;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int KEY_MIN        = 32'sh8000_0000;
	localparam int KEY_MAX        = 32'sh7FFF_FFFF;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    opcode = OP_INSERT;
	logic signed [KEY_W-1:0] value = '0;
	logic                    run_done = 1'b0;
	logic                    busy;
	logic                    done;
	logic                    changed;
	logic                    full_reject;
	logic [OCC_W-1:0]        occupancy;

	int fail_count;
	int pending;
	int results_seen;
	int rejects_seen;

	int idle_pct = 0;
	int n_inserts = 0;
	int n_deletes = 0;
	int quiet_cycles = 0;
	int key_pool[POOL_SIZE];
	int fresh_q[$];
	int idle_levels[3] = '{0, 46, 28};

	always #6 clk = ~clk;

	sorted_unique_set_unit #(.CAPACITY(CAPACITY)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.value      (value),
		.done       (done),
		.changed    (changed),
		.full_reject(full_reject),
		.occupancy  (occupancy)
	);

	sorted_unique_set_unit_checker #(.CAPACITY(CAPACITY)) set_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.value       (value),
		.done        (done),
		.changed     (changed),
		.full_reject (full_reject),
		.occupancy   (occupancy),
		.run_done    (run_done),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.rejects_seen(rejects_seen)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a transaction", quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// within send_op, start is only lowered in the idle loop, so back-to-back sends keep it high
	task automatic send_op(input logic op, input int key);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		opcode <= op;
		value  <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == OP_INSERT)
			n_inserts++;
		else
			n_deletes++;
	endtask

	task automatic shuffle_pool();
		int j;
		int tmp;
		for (int i = POOL_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = key_pool[i];
			key_pool[i] = key_pool[j];
			key_pool[j] = tmp;
		end
	endtask

	task automatic run_round(input int round_no);
		int r;
		int k;
		idle_pct = idle_levels[round_no % 3];
		// pairs of adjacent keys exercise the low compare bits
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i % 2 == 0) ? int'($urandom) : key_pool[i-1] + 1;
		if (round_no % 2 == 1) begin
			key_pool[0] = KEY_MIN;
			key_pool[1] = KEY_MIN + 1;
			key_pool[2] = KEY_MAX - 1;
			key_pool[3] = KEY_MAX;
		end

		// fill past capacity, with some stray transactions mixed in
		shuffle_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if ($urandom_range(9) == 0) begin
				k = $urandom;
				if ($urandom_range(1) == 0) begin
					fresh_q.push_back(k);
					send_op(OP_INSERT, k);
				end else begin
					send_op(OP_DELETE, k);
				end
			end
			send_op(OP_INSERT, key_pool[i]);
		end

		// mixed traffic on a full or nearly full store
		for (int i = 0; i < MIX_ITEMS; i++) begin
			r = $urandom_range(99);
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
			if (r < 40) begin
				send_op(OP_INSERT, k);
			end else if (r < 80) begin
				send_op(OP_DELETE, k);
			end else if (r < 90) begin
				k = $urandom;
				fresh_q.push_back(k);
				send_op(OP_INSERT, k);
			end else begin
				send_op(OP_DELETE, $urandom);
			end
		end

		// drain everything this round could have stored
		shuffle_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			send_op(OP_DELETE, key_pool[i]);
		while (fresh_q.size() > 0)
			send_op(OP_DELETE, fresh_q.pop_front());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases
		send_op(OP_DELETE, 0);
		send_op(OP_INSERT, 0);
		send_op(OP_INSERT, KEY_MAX);
		send_op(OP_INSERT, KEY_MIN);
		send_op(OP_INSERT, -1);
		send_op(OP_INSERT, 1);
		send_op(OP_INSERT, 0);
		send_op(OP_INSERT, KEY_MIN);
		send_op(OP_DELETE, 2);
		send_op(OP_DELETE, KEY_MIN);
		send_op(OP_DELETE, KEY_MIN);
		send_op(OP_DELETE, KEY_MAX);
		send_op(OP_INSERT, 32'h5555_5555);
		send_op(OP_INSERT, 32'hAAAA_AAAA);
		send_op(OP_DELETE, 0);
		send_op(OP_DELETE, -1);
		send_op(OP_DELETE, 1);
		send_op(OP_DELETE, 32'h5555_5555);
		send_op(OP_DELETE, 32'hAAAA_AAAA);
		send_op(OP_DELETE, KEY_MAX);

		for (int rnd = 0; rnd < ROUNDS; rnd++)
			run_round(rnd);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		run_done <= 1'b1;
		@(posedge clk);

		$display("Sent %0d inserts and %0d deletes: corner cases, then %0d fill/mix/drain rounds",
			n_inserts, n_deletes, ROUNDS);
		$display("Compared %0d results, %0d of them inserts refused by a full store",
			results_seen, rejects_seen);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/sus_pkg.sv
src/sus_cell.sv
src/sorted_unique_set_unit.sv
src/sus_checker.sv
dv/sorted_unique_set_unit_checker.sv
dv/sorted_unique_set_unit_tb.sv
